// ----- hw/rtl/kst_pkg.sv -----
// Package for the keyed set table: request and response types, operation
// and status codes, and the sequencer state type.
// No dependencies.
package kst_pkg;

  // Operation codes carried in a request
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_POP    = 2'd3
  } kst_op_e;

  // Response status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_EMPTY    = 3'd4
  } kst_status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RM_RD,
    S_RM_WR,
    S_POP_RD,
    S_POP_WB,
    S_DONE
  } kst_state_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned HdlW   = 32;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    kst_op_e                  operation;
    logic signed [KeyW-1:0]   key_id;
    logic        [HdlW-1:0]   entry_handle;
  } kst_req_t;

  typedef struct packed {
    kst_status_e              status;
    logic                     found;
    logic        [HdlW-1:0]   result_handle;
    logic        [CountW-1:0] entry_count;
  } kst_rsp_t;

endpackage

// ----- hw/rtl/keyed_set_table_top.sv -----
// Keyed set table top level: sequencer, key/handle memories, one shared
// key comparator and the response register.
// Depends on kst_pkg.

// Unordered set of up to CAPACITY key/handle entries. Add, remove and lookup
// search the held entries linearly, one entry per cycle through the single
// read port of the key/handle memories and one 32-bit key comparator. Remove
// moves the last entry into the freed slot. A finished response sits in an
// output register, so a new request is taken while the previous response
// still waits downstream; the following response then keeps the block busy
// until that register is taken. The memories need no clearing after reset:
// only entries below the fill count are ever read.
module keyed_set_table_top
  import kst_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  kst_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output kst_rsp_t out_rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Control state
  kst_state_e      state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic            out_vld_q, out_vld_d;

  // Request and result payload
  kst_op_e         op_q, op_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [HdlW-1:0] hdl_q, hdl_d;
  logic [AW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]   slot_q, slot_d;
  kst_rsp_t        res_q, res_d;
  kst_rsp_t        out_q, out_d;

  // Memory ports
  logic [KeyW-1:0] key_mem [CAPACITY];
  logic [HdlW-1:0] hdl_mem [CAPACITY];
  logic [KeyW-1:0] key_rd_q;
  logic [HdlW-1:0] hdl_rd_q;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [KeyW-1:0] wr_key;
  logic [HdlW-1:0] wr_hdl;

  logic            accept;
  logic            hit;
  logic            more;
  logic            out_free;
  logic [CW-1:0]   cnt_last;
  logic [CW-1:0]   cnt_inc;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign hit      = cmp_vld_q && (key_rd_q == key_q);
  assign more     = idx_q < cnt_q;
  assign out_free = !out_vld_q || !out_stall_i;
  assign cnt_last = cnt_q - CW'(1);
  assign cnt_inc  = cnt_q + CW'(1);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_req_i.operation == OP_POP) begin
            state_d = (cnt_q == '0) ? S_DONE : S_POP_RD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = (op_q == OP_REMOVE) ? S_RM_RD : S_DONE;
        end else if (!more) begin
          state_d = S_DONE;
        end
      end
      S_RM_RD:  state_d = S_RM_WR;
      S_RM_WR:  state_d = S_DONE;
      S_POP_RD: state_d = S_POP_WB;
      S_POP_WB: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_d      = op_q;
    key_d     = key_q;
    hdl_d     = hdl_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    slot_d    = slot_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    rd_addr   = idx_q[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = cnt_q[AW-1:0];
    wr_key    = key_q;
    wr_hdl    = hdl_q;

    // Output register: drain on take, load from the finished result
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (state_q == S_DONE && out_free) begin
      out_d     = res_q;
      out_vld_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = in_req_i.operation;
          key_d     = in_req_i.key_id;
          hdl_d     = in_req_i.entry_handle;
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          res_d.status        = STAT_EMPTY;
          res_d.found         = 1'b0;
          res_d.result_handle = '0;
          res_d.entry_count   = CountW'(cnt_q);
        end
      end
      S_SCAN: begin
        if (hit) begin
          // Key present at the slot compared this cycle
          slot_d              = cmp_idx_q;
          res_d.found         = 1'b1;
          res_d.result_handle = hdl_rd_q;
          res_d.entry_count   = CountW'(cnt_q);
          res_d.status        = (op_q == OP_ADD) ? STAT_DUP : STAT_OK;
        end else if (more) begin
          // Issue the next entry read; compare it next cycle
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end else begin
          // Key absent
          res_d.found         = 1'b0;
          res_d.result_handle = '0;
          res_d.entry_count   = CountW'(cnt_q);
          if (op_q == OP_ADD) begin
            if (cnt_q == CW'(CAPACITY)) begin
              res_d.status = STAT_FULL;
            end else begin
              wr_en             = 1'b1;
              wr_addr           = cnt_q[AW-1:0];
              cnt_d             = cnt_inc;
              res_d.status      = STAT_OK;
              res_d.entry_count = CountW'(cnt_inc);
            end
          end else begin
            res_d.status = STAT_NOTFOUND;
          end
        end
      end
      S_RM_RD: begin
        rd_addr = cnt_last[AW-1:0];
      end
      S_RM_WR: begin
        // Move the last entry into the freed slot
        wr_en             = 1'b1;
        wr_addr           = slot_q;
        wr_key            = key_rd_q;
        wr_hdl            = hdl_rd_q;
        cnt_d             = cnt_last;
        res_d.entry_count = CountW'(cnt_last);
      end
      S_POP_RD: begin
        rd_addr = cnt_last[AW-1:0];
      end
      S_POP_WB: begin
        cnt_d               = cnt_last;
        res_d.status        = STAT_OK;
        res_d.found         = 1'b1;
        res_d.result_handle = hdl_rd_q;
        res_d.entry_count   = CountW'(cnt_last);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    hdl_q     <= hdl_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Key and handle memories: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      hdl_mem[wr_addr] <= wr_hdl;
    end
    key_rd_q <= key_mem[rd_addr];
    hdl_rd_q <= hdl_mem[rd_addr];
  end

endmodule

// ----- hw/rtl/kst_chk.sv -----
// Port-level checker for the keyed set table, bound to the top level.
// Depends on kst_pkg and keyed_set_table_top.
module kst_chk
  import kst_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input kst_rsp_t out_rsp_o
);

  // A stalled response stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // An accepted request keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after accepting a request");

  // Failed operations report no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == STAT_NOTFOUND ||
                    out_rsp_o.status == STAT_FULL ||
                    out_rsp_o.status == STAT_EMPTY)
    |-> !out_rsp_o.found && out_rsp_o.result_handle == '0)
    else $error("failed operation reports an entry");

  // Full and empty responses agree with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == STAT_FULL
    |-> out_rsp_o.entry_count == CountW'(CAPACITY))
    else $error("full status with count below capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == STAT_EMPTY |-> out_rsp_o.entry_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind keyed_set_table_top kst_chk #(.CAPACITY(CAPACITY)) u_kst_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

// ----- bench/tb_keyed_set_table_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for keyed_set_table_top: clocked driver and monitor,
// a behavioral set model, and per-field checking of every response.
// Depends on kst_pkg and keyed_set_table_top.
module tb_keyed_set_table_top;
  import kst_pkg::*;

  localparam int unsigned Cap       = 16;
  localparam int unsigned PoolSize  = 24;
  localparam int unsigned PhaseReqs = 500;
  localparam int unsigned ChunkReqs = 50;
  localparam int unsigned MaxPrint  = 30;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  kst_req_t in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  kst_rsp_t out_rsp_o;

  keyed_set_table_top #(
    .CAPACITY(Cap)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Requests waiting to be driven and responses the set model predicts
  kst_req_t req_pending[$];
  kst_rsp_t rsp_expected[$];

  // Set model state
  logic [KeyW-1:0] held_keys[Cap];
  logic [HdlW-1:0] held_handles[Cap];
  int              held_count;
  int              peak_count;

  logic [KeyW-1:0] key_pool[PoolSize];
  int              send_idle_pct;
  int              recv_idle_pct;
  int              error_count;
  int              op_seen[4];
  int              status_seen[5];
  kst_rsp_t        exp_rsp;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("tb_keyed_set_table_top failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] exp_v);
    if (error_count < MaxPrint)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got_v, exp_v);
    error_count++;
  endtask

  // Set model: one response per request, state updated in place
  function automatic kst_rsp_t set_response(input kst_req_t req);
    kst_rsp_t rsp;
    int       slot;
    int       i;
    rsp = '0;
    rsp.status = STAT_OK;
    slot = -1;
    if (req.operation == OP_POP) begin
      if (held_count == 0) begin
        rsp.status = STAT_EMPTY;
      end else begin
        held_count--;
        rsp.found = 1'b1;
        rsp.result_handle = held_handles[held_count];
      end
    end else begin
      for (i = 0; i < held_count; i++)
        if (slot < 0 && held_keys[i] == req.key_id) slot = i;
      if (req.operation == OP_ADD) begin
        if (slot >= 0) begin
          rsp.status = STAT_DUP;
          rsp.found = 1'b1;
          rsp.result_handle = held_handles[slot];
        end else if (held_count >= Cap) begin
          rsp.status = STAT_FULL;
        end else begin
          held_keys[held_count] = req.key_id;
          held_handles[held_count] = req.entry_handle;
          held_count++;
        end
      end else if (slot < 0) begin
        rsp.status = STAT_NOTFOUND;
      end else begin
        rsp.found = 1'b1;
        rsp.result_handle = held_handles[slot];
        // remove fills the hole with the last entry
        if (req.operation == OP_REMOVE) begin
          held_keys[slot] = held_keys[held_count-1];
          held_handles[slot] = held_handles[held_count-1];
          held_count--;
        end
      end
    end
    if (held_count > peak_count) peak_count = held_count;
    rsp.entry_count = CountW'(held_count);
    return rsp;
  endfunction

  function automatic void queue_req(input kst_op_e op, input logic [KeyW-1:0] key,
                                    input logic [HdlW-1:0] hdl);
    kst_req_t req;
    req.operation = op;
    req.key_id = key;
    req.entry_handle = hdl;
    req_pending.push_back(req);
  endfunction

  // Fresh key pool: extremes plus random keys
  function automatic void refresh_pool();
    int i;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0000_0000;
    for (i = 4; i < PoolSize; i++) key_pool[i] = $urandom;
  endfunction

  // Mostly keys from the pool so hits, duplicates and full sets occur;
  // some fully random keys as noise
  function automatic void queue_random_req(input int add_pct);
    int              pick;
    kst_op_e         op;
    logic [KeyW-1:0] key;
    pick = $urandom_range(99);
    if (pick < add_pct) op = OP_ADD;
    else if (pick < add_pct + (100 - add_pct) / 3) op = OP_REMOVE;
    else if (pick < add_pct + 2 * (100 - add_pct) / 3) op = OP_LOOKUP;
    else op = OP_POP;
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(PoolSize-1)];
    else key = $urandom;
    queue_req(op, key, $urandom);
  endfunction

  // Sender pauses until every predicted response has come back
  task automatic wait_drained();
    while (req_pending.size() != 0 || rsp_expected.size() != 0 || in_valid_i)
      @(negedge clk_i);
  endtask

  // Driver: predict on acceptance, then present the next request or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rsp_expected.push_back(set_response(in_req_i));
        op_seen[int'(in_req_i.operation)]++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i <= req_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall, compare each accepted response with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (rsp_expected.size() == 0) begin
          report_mismatch("unexpected response", 64'(out_rsp_o), 64'd0);
        end else begin
          exp_rsp = rsp_expected.pop_front();
          if (int'(exp_rsp.status) < 5) status_seen[int'(exp_rsp.status)]++;
          if (out_rsp_o.status !== exp_rsp.status)
            report_mismatch("status", 64'(out_rsp_o.status), 64'(exp_rsp.status));
          if (out_rsp_o.found !== exp_rsp.found)
            report_mismatch("found", 64'(out_rsp_o.found), 64'(exp_rsp.found));
          if (out_rsp_o.result_handle !== exp_rsp.result_handle)
            report_mismatch("result_handle", 64'(out_rsp_o.result_handle),
                            64'(exp_rsp.result_handle));
          if (out_rsp_o.entry_count !== exp_rsp.entry_count)
            report_mismatch("entry_count", 64'(out_rsp_o.entry_count),
                            64'(exp_rsp.entry_count));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Stimulus and end of run
  initial begin
    int phase;
    int chunk;
    int n;
    int add_pct;
    held_count = 0;
    peak_count = 0;
    error_count = 0;
    for (n = 0; n < 4; n++) op_seen[n] = 0;
    for (n = 0; n < 5; n++) status_seen[n] = 0;
    send_idle_pct = 17;
    recv_idle_pct = 63;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty set, extreme keys and handles, fill to full,
    // full refusal, duplicate while full, miss on a full set, remove with move
    queue_req(OP_POP, $urandom, $urandom);
    queue_req(OP_REMOVE, 32'h0000_0000, $urandom);
    queue_req(OP_LOOKUP, 32'h7fff_ffff, $urandom);
    queue_req(OP_ADD, 32'h8000_0000, 32'h0000_0000);
    queue_req(OP_ADD, 32'h7fff_ffff, 32'hffff_ffff);
    queue_req(OP_ADD, 32'hffff_ffff, 32'h5a5a_5a5a);
    queue_req(OP_ADD, 32'h0000_0000, 32'ha5a5_a5a5);
    queue_req(OP_ADD, 32'haaaa_aaaa, $urandom);
    queue_req(OP_ADD, 32'h5555_5555, $urandom);
    for (n = 0; n < Cap - 6; n++) queue_req(OP_ADD, 32'h1000_0000 + n, $urandom);
    queue_req(OP_ADD, 32'h1234_5678, $urandom);
    queue_req(OP_ADD, 32'hffff_ffff, $urandom);
    queue_req(OP_LOOKUP, 32'h5555_5555, $urandom);
    queue_req(OP_LOOKUP, 32'hdead_beef, $urandom);
    queue_req(OP_REMOVE, 32'h8000_0000, $urandom);
    queue_req(OP_LOOKUP, 32'h1000_0000 + Cap - 7, $urandom);
    queue_req(OP_POP, $urandom, $urandom);
    wait_drained();

    // Random phases; the add bias changes per chunk so the set fills and empties
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      refresh_pool();
      for (chunk = 0; chunk < PhaseReqs / ChunkReqs; chunk++) begin
        case ($urandom_range(2))
          0: add_pct = 20;
          1: add_pct = 45;
          default: add_pct = 75;
        endcase
        for (n = 0; n < ChunkReqs; n++) queue_random_req(add_pct);
        while (req_pending.size() > 10) @(negedge clk_i);
        if (chunk == 4) wait_drained();
      end
      wait_drained();
    end

    // Let any stray response show up
    repeat (40) @(posedge clk_i);
    $display("covered add/remove/lookup/pop %0d/%0d/%0d/%0d requests, peak fill %0d of %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], peak_count, Cap);
    $display("responses ok/dup/notfound/full/empty %0d/%0d/%0d/%0d/%0d, %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], error_count);
    if (error_count == 0 && rsp_expected.size() == 0) begin
      $display("tb_keyed_set_table_top passed");
    end else begin
      $display("tb_keyed_set_table_top failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/kst_pkg.sv
hw/rtl/keyed_set_table_top.sv
hw/rtl/kst_chk.sv
bench/tb_keyed_set_table_top.sv
